[rtl/itf_pkg.sv]
// itf_pkg: shared types, constants and the digit-to-ASCII helper for the
// integer text formatter. No dependencies; used by every rtl/itf_* file
// and by the top level.
`timescale 1ns / 1ps
package itf_pkg;

  localparam int ValW      = 64;
  localparam int DecDigits = 20;
  localparam int FieldW    = 5;
  localparam int NdW       = $clog2(DecDigits + 1);
  localparam int TotW      = 7;
  localparam int InDataW   = 80;
  localparam int OutDataW  = 8;

  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] ChA     = 8'h61;

  // digit 0 is the least significant
  typedef logic [DecDigits-1:0][3:0] digits_t;

  typedef struct packed {
    logic              mode;
    logic              width_given;
    logic [FieldW-1:0] field_width;
    logic              prec_given;
    logic [FieldW-1:0] precision;
    logic              left_align;
    logic              alt_prefix;
  } fmt_t;

  typedef struct packed {
    logic           neg;
    logic           hex_zero;
    logic [NdW-1:0] nd;
  } conv_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [3:0] off;
    off = d - 4'd10;
    digit_char = (d < 4'd10) ? (ChZero + {4'd0, d}) : (ChA + {4'd0, off});
  endfunction

endpackage

[rtl/itf_conv.sv]
// itf_conv: shared shift unit that turns the value into digits, two
// double-dabble bits per cycle in decimal, one nibble per cycle in hex.
// Depends on itf_pkg.
`timescale 1ns / 1ps
module itf_conv (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      mode,
  input  logic [itf_pkg::ValW-1:0]  value,
  output logic                      done,
  output itf_pkg::digits_t          digits,
  output itf_pkg::conv_stat_t       stat
);
  import itf_pkg::*;

  localparam int CntW = 6;
  localparam logic [CntW-1:0] DecSteps = CntW'(ValW / 2);
  localparam logic [CntW-1:0] HexSteps = CntW'(ValW / 4);

  logic            busy;
  logic            mode_r;
  logic            neg;
  logic            started;
  logic [NdW-1:0]  nd;
  logic [CntW-1:0] cnt;
  logic [ValW-1:0] mag;
  digits_t         bcd;

  digits_t         bcd_step;
  logic [3:0]      nib;
  logic            nd_grow;
  logic            is_neg;

  function automatic digits_t dabble(input digits_t b, input logic bin);
    digits_t                a;
    logic [4*DecDigits:0]   w;
    for (int i = 0; i < DecDigits; i++) begin
      a[i] = (b[i] >= 4'd5) ? (b[i] + 4'd3) : b[i];
    end
    w = {a, bin};
    dabble = w[4*DecDigits-1:0];
  endfunction

  assign is_neg = !mode && value[ValW-1];

  always_comb begin
    bcd_step = dabble(dabble(bcd, mag[ValW-1]), mag[ValW-2]);
    nib      = mag[ValW-1 -: 4];
    // value at most quadruples per cycle, so at most one new digit appears
    nd_grow  = (nd < NdW'(DecDigits)) && (bcd_step[nd] != 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      mode_r  <= 1'b0;
      neg     <= 1'b0;
      started <= 1'b0;
      nd      <= '0;
      cnt     <= '0;
    end else begin
      done <= busy && (cnt == CntW'(1));
      if (start) begin
        busy    <= 1'b1;
        mode_r  <= mode;
        neg     <= is_neg;
        started <= 1'b0;
        nd      <= mode ? NdW'(0) : NdW'(1);
        cnt     <= mode ? HexSteps : DecSteps;
      end else if (busy) begin
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
        end
        if (mode_r) begin
          // leading zero nibbles are dropped
          if (started || nib != 4'd0) begin
            nd      <= nd + NdW'(1);
            started <= 1'b1;
          end
        end else if (nd_grow) begin
          nd <= nd + NdW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag <= is_neg ? (ValW'(0) - value) : value;
      bcd <= '0;
    end else if (busy) begin
      if (mode_r) begin
        mag <= mag << 4;
        if (started || nib != 4'd0) begin
          bcd <= {bcd[DecDigits-2:0], nib};
        end
      end else begin
        mag <= mag << 2;
        bcd <= bcd_step;
      end
    end
  end

  assign digits        = bcd;
  assign stat.neg      = neg;
  assign stat.hex_zero = mode_r && !started;
  assign stat.nd       = (mode_r && !started) ? NdW'(1) : nd;

  a_nd_range: assert property (@(posedge clk) disable iff (rst)
    nd <= NdW'(DecDigits))
    else $error("itf_conv: digit count beyond digit store");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("itf_conv: done while still converting");

endmodule

[rtl/itf_emit.sv]
// itf_emit: plans the padding counts and sends one character per beat
// through a registered output stage. Depends on itf_pkg.
`timescale 1ns / 1ps
module itf_emit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  itf_pkg::fmt_t                   fmt,
  input  itf_pkg::conv_stat_t             stat,
  input  itf_pkg::digits_t                digits,
  input  logic                            m_tready,
  output logic                            m_tvalid,
  output logic [itf_pkg::OutDataW-1:0]    m_tdata,
  output logic                            m_tlast,
  output logic                            m_tuser,
  output logic                            done
);
  import itf_pkg::*;

  logic [FieldW-1:0] sp_p;
  logic [FieldW-1:0] z_p;
  logic              pre_p;
  logic [FieldW-1:0] dig_p;
  logic [TotW-1:0]   tot_p;

  logic              active;
  logic              sign_r;
  logic [FieldW-1:0] sp;
  logic [1:0]        pre;
  logic [FieldW-1:0] z;
  logic [NdW-1:0]    dp;
  logic [TotW-1:0]   rem;

  logic              take;
  logic [7:0]        ch;

  always_comb begin
    sp_p  = '0;
    z_p   = '0;
    pre_p = 1'b0;
    if (fmt.width_given) begin
      if (fmt.prec_given) begin
        if (!fmt.left_align && fmt.field_width > fmt.precision) begin
          sp_p = fmt.field_width - fmt.precision;
        end
        if (fmt.precision > stat.nd) begin
          z_p = fmt.precision - stat.nd;
        end
      end else if (!fmt.left_align) begin
        if (fmt.field_width > stat.nd) begin
          sp_p = fmt.field_width - stat.nd;
        end
        pre_p = fmt.mode && fmt.alt_prefix;
      end
    end else if (fmt.prec_given) begin
      if (fmt.precision > stat.nd) begin
        z_p = fmt.precision - stat.nd;
      end
    end
    // a hex zero always shows its one digit; otherwise precision cuts
    if (stat.hex_zero) begin
      dig_p = FieldW'(1);
    end else if (fmt.prec_given && fmt.precision < stat.nd) begin
      dig_p = fmt.precision;
    end else begin
      dig_p = stat.nd;
    end
    tot_p = TotW'(stat.neg) + TotW'(sp_p) + TotW'({pre_p, 1'b0}) + TotW'(z_p)
          + TotW'(dig_p);
  end

  assign take = active && (!m_tvalid || m_tready);

  always_comb begin
    if (sign_r) begin
      ch = ChMinus;
    end else if (sp != '0) begin
      ch = ChSpace;
    end else if (pre != 2'd0) begin
      ch = (pre == 2'd2) ? ChZero : ChX;
    end else if (z != '0) begin
      ch = ChZero;
    end else begin
      ch = digit_char(digits[dp]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      m_tvalid <= 1'b0;
      done     <= 1'b0;
      sign_r   <= 1'b0;
      sp       <= '0;
      pre      <= '0;
      z        <= '0;
      dp       <= '0;
      rem      <= '0;
    end else begin
      done <= take && (rem <= TotW'(1));
      if (take) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (start) begin
        active <= 1'b1;
        sign_r <= stat.neg;
        sp     <= sp_p;
        pre    <= pre_p ? 2'd2 : 2'd0;
        z      <= z_p;
        dp     <= stat.nd - NdW'(1);
        rem    <= tot_p;
      end else if (take) begin
        if (rem <= TotW'(1)) begin
          active <= 1'b0;
        end else begin
          rem <= rem - TotW'(1);
        end
        if (sign_r) begin
          sign_r <= 1'b0;
        end else if (sp != '0) begin
          sp <= sp - FieldW'(1);
        end else if (pre != 2'd0) begin
          pre <= pre - 2'd1;
        end else if (z != '0) begin
          z <= z - FieldW'(1);
        end else begin
          dp <= dp - NdW'(1);
        end
      end
    end
  end

  // empty conversion: a single flagged beat with zero data
  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= (rem == '0) ? '0 : ch;
      m_tlast <= (rem <= TotW'(1));
      m_tuser <= (rem == '0);
    end
  end

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    done |-> m_tvalid && m_tlast)
    else $error("itf_emit: done without a final beat loaded");

  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
    else $error("itf_emit: empty beat not final or carries data");

endmodule

[rtl/integer_text_formatter_core.sv]
// integer_text_formatter_core: top level of the integer text formatter.
// Instantiates itf_conv and itf_emit; uses itf_pkg.
//
// Usage:
//   Input channel s_*: one beat per conversion. s_tuser is the mode
//   (0 signed decimal, 1 lower-case hex); s_tdata carries the value and
//   the format fields. Output channel m_*: one beat per character, ASCII
//   in m_tdata, m_tlast on the final character. A conversion that yields
//   no text gives one beat with m_tuser set, m_tdata zero and m_tlast set.
//   Conversion: decimal digits come from the shared double-dabble shifter
//   at two bits per cycle, hex digits at one nibble per cycle; the emitter
//   then plans the padding and sends the characters, one per beat, while
//   m_tready is high. s_tready is high only while no conversion is in
//   progress; it returns after the last beat enters the output register,
//   once the emitter's registered done flag has brought the state
//   register back to idle. A stalled receiver holds the output
//   register and pauses the character sequencer. Reset clears the
//   sequencers and leaves the block idle and ready.
`timescale 1ns / 1ps
module integer_text_formatter_core #(
  parameter int MAX_FIELD = 31
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [63:0] value, [64] width_given, [69:65] field_width, [70] prec_given,
  // [75:71] precision, [76] left_align, [77] alt_prefix, [79:78] zero
  input  logic [itf_pkg::InDataW-1:0]     s_tdata,
  // [0] mode
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [7:0] out_char
  output logic [itf_pkg::OutDataW-1:0]    m_tdata,
  output logic                            m_tlast,
  // [0] empty_res
  output logic                            m_tuser
);
  import itf_pkg::*;

  localparam int FieldTop = (1 << FieldW) - 1;
  localparam int FieldCap = (MAX_FIELD < FieldTop) ? MAX_FIELD : FieldTop;
  localparam logic [FieldW-1:0] FieldMax = FieldW'(FieldCap);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state;
  logic              accept;
  fmt_t              fmt;
  logic [FieldW-1:0] fw_in;
  logic [FieldW-1:0] pr_in;

  logic              conv_done;
  digits_t           digits;
  conv_stat_t        stat;
  logic              emit_done;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign fw_in = s_tdata[69:65];
  assign pr_in = s_tdata[75:71];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) state <= ST_CONV;
        end
        ST_CONV: begin
          if (conv_done) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_done) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fmt.mode        <= s_tuser;
      fmt.width_given <= s_tdata[64];
      fmt.field_width <= (fw_in > FieldMax) ? FieldMax : fw_in;
      fmt.prec_given  <= s_tdata[70];
      fmt.precision   <= (pr_in > FieldMax) ? FieldMax : pr_in;
      fmt.left_align  <= s_tdata[76];
      fmt.alt_prefix  <= s_tdata[77];
    end
  end

  itf_conv u_conv (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .mode   (s_tuser),
    .value  (s_tdata[ValW-1:0]),
    .done   (conv_done),
    .digits (digits),
    .stat   (stat)
  );

  itf_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .start    (conv_done),
    .fmt      (fmt),
    .stat     (stat),
    .digits   (digits),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .done     (emit_done)
  );

  a_conv_phase: assert property (@(posedge clk) disable iff (rst)
    conv_done |-> state == ST_CONV)
    else $error("core: conversion finished outside conversion phase");

  a_emit_phase: assert property (@(posedge clk) disable iff (rst)
    emit_done |-> state == ST_EMIT)
    else $error("core: emitter finished outside emit phase");

endmodule

[dv/tb_top.sv]
// tb_top: self-checking bench for integer_text_formatter_core. Sends conversion requests,
// predicts or looks up the character stream per request and checks every output beat in order.
// Depends on rtl/itf_pkg.sv and rtl/integer_text_formatter_core.sv.
`timescale 1ns / 1ps
module tb_top;

  import itf_pkg::*;

  localparam int MaxField    = 31;
  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 60;
  localparam int RandItems   = 104;
  localparam string HexChars = "0123456789abcdef";

  typedef enum logic [1:0] {ROW_PREDICT, ROW_TEXT, ROW_EMPTY} row_kind_t;

  typedef struct {
    fmt_t      f;
    bit [63:0] v;
    row_kind_t kind;
    string     txt;
  } dir_row_t;

  typedef struct {
    bit [7:0] ch;
    bit       last;
    bit       empty;
  } text_beat_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tlast;
  logic                m_tuser;

  text_beat_t pending_chars[$];
  dir_row_t   dir_rows[$];
  int         mismatches  = 0;
  int         idle_cycles = 0;
  bit         send_calm   = 0;

  integer_text_formatter_core #(.MAX_FIELD(MaxField)) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void push_beat(bit [7:0] ch, bit last, bit empty);
    text_beat_t b;
    b.ch    = ch;
    b.last  = last;
    b.empty = empty;
    pending_chars.push_back(b);
  endfunction

  // expected character stream of one conversion
  function automatic void predict_text(fmt_t f, bit [63:0] v);
    bit [7:0]  digs[$];
    bit [7:0]  txt[$];
    bit [63:0] mag;
    bit [3:0]  nib;
    bit        hex_zero;
    int        fw;
    int        pr;
    int        nd;
    int        cnt;
    hex_zero = 1'b0;
    fw = (f.field_width > MaxField) ? MaxField : int'(f.field_width);
    pr = (f.precision > MaxField) ? MaxField : int'(f.precision);
    if (!f.mode) begin
      mag = v;
      if (v[63]) begin
        txt.push_back("-");
        mag = -v;
      end
      do begin
        digs.push_front(8'h30 + 8'(mag % 64'd10));
        mag = mag / 64'd10;
      end while (mag != 0);
    end else begin
      for (int i = 15; i >= 0; i--) begin
        nib = v[i*4 +: 4];
        if (nib != 0 || digs.size() != 0) digs.push_back(HexChars[nib]);
      end
      if (digs.size() == 0) begin
        hex_zero = 1'b1;
        digs.push_back("0");
      end
    end
    nd = digs.size();
    if (f.width_given) begin
      if (f.prec_given) begin
        if (!f.left_align && fw > pr)
          for (int i = 0; i < fw - pr; i++) txt.push_back(" ");
        for (int i = 0; i < pr - nd; i++) txt.push_back("0");
      end else if (!f.left_align) begin
        for (int i = 0; i < fw - nd; i++) txt.push_back(" ");
        if (f.mode && f.alt_prefix) begin
          txt.push_back("0");
          txt.push_back("x");
        end
      end
    end else if (f.prec_given) begin
      for (int i = 0; i < pr - nd; i++) txt.push_back("0");
    end
    if (hex_zero) begin
      txt.push_back("0");
    end else begin
      cnt = (f.prec_given && pr < nd) ? pr : nd;
      for (int i = 0; i < cnt; i++) txt.push_back(digs[i]);
    end
    if (txt.size() == 0) push_beat(8'h00, 1'b1, 1'b1);
    else
      foreach (txt[i]) push_beat(txt[i], i == txt.size() - 1, 1'b0);
  endfunction

  function automatic void add_row(bit mode, bit [63:0] v, bit wg, bit [4:0] fw, bit pg,
                                  bit [4:0] pr, bit la, bit ax, row_kind_t kind, string txt);
    dir_row_t r;
    r.f.mode        = mode;
    r.f.width_given = wg;
    r.f.field_width = fw;
    r.f.prec_given  = pg;
    r.f.precision   = pr;
    r.f.left_align  = la;
    r.f.alt_prefix  = ax;
    r.v    = v;
    r.kind = kind;
    r.txt  = txt;
    dir_rows.push_back(r);
  endfunction

  function automatic bit [63:0] pick_value();
    bit [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: pick_value = 64'($urandom_range(0, 20));
      1: pick_value = -64'($urandom_range(1, 20));
      2: pick_value = r >> $urandom_range(0, 63);
      3: begin
        case ($urandom_range(0, 3))
          0: pick_value = 64'h8000_0000_0000_0000;
          1: pick_value = 64'h7fff_ffff_ffff_ffff;
          2: pick_value = 64'hffff_ffff_ffff_ffff;
          default: pick_value = 64'h0;
        endcase
      end
      default: pick_value = r;
    endcase
  endfunction

  function automatic fmt_t pick_format();
    fmt_t f;
    f.mode        = 1'($urandom_range(0, 1));
    f.width_given = 1'($urandom_range(0, 1));
    f.field_width = 5'($urandom_range(0, 31));
    f.prec_given  = 1'($urandom_range(0, 1));
    f.precision   = 5'($urandom_range(0, 31));
    f.left_align  = 1'($urandom_range(0, 1));
    f.alt_prefix  = 1'($urandom_range(0, 1));
    return f;
  endfunction

  // one request beat; the expectation is queued at the accepting edge
  task automatic send_conversion(fmt_t f, bit [63:0] v, row_kind_t kind, string txt);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f.mode;
    s_tdata  <= {2'b00, f.alt_prefix, f.left_align, f.precision, f.prec_given,
                 f.field_width, f.width_given, v};
    do @(posedge clk); while (!s_tready);
    case (kind)
      ROW_PREDICT: predict_text(f, v);
      ROW_EMPTY:   push_beat(8'h00, 1'b1, 1'b1);
      default:
        for (int i = 0; i < txt.len(); i++) push_beat(txt[i], i == txt.len() - 1, 1'b0);
    endcase
  endtask

  // request side
  initial begin : request_feed
    fmt_t f;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    rst      = 1'b1;
    //      mode value                  wg fw  pg pr  la ax
    add_row(0, 64'd0,                   0, 0,  0, 0,  0, 0, ROW_TEXT, "0");
    add_row(0, 64'hffff_ffff_ffff_ffff, 0, 0,  0, 0,  0, 0, ROW_TEXT, "-1");
    add_row(0, 64'h8000_0000_0000_0000, 0, 0,  0, 0,  0, 0, ROW_TEXT,
            "-9223372036854775808");
    add_row(0, 64'h7fff_ffff_ffff_ffff, 0, 0,  0, 0,  0, 0, ROW_TEXT, "9223372036854775807");
    add_row(1, 64'hffff_ffff_ffff_ffff, 0, 0,  0, 0,  0, 0, ROW_TEXT, "ffffffffffffffff");
    add_row(1, 64'd0,                   0, 0,  0, 0,  0, 0, ROW_TEXT, "0");
    add_row(1, 64'd0,                   0, 0,  1, 0,  0, 0, ROW_TEXT, "0");
    add_row(0, 64'd0,                   0, 0,  1, 0,  0, 0, ROW_EMPTY, "");
    add_row(1, 64'h1234,                0, 0,  1, 0,  0, 0, ROW_EMPTY, "");
    add_row(0, -64'd5,                  0, 0,  1, 0,  0, 0, ROW_TEXT, "-");
    add_row(0, 64'd42,                  1, 5,  0, 0,  0, 0, ROW_TEXT, "   42");
    add_row(0, 64'd42,                  1, 5,  0, 0,  1, 0, ROW_TEXT, "42");
    add_row(1, 64'hab,                  1, 6,  0, 0,  0, 1, ROW_TEXT, "    0xab");
    add_row(1, 64'hab,                  1, 6,  0, 0,  1, 1, ROW_TEXT, "ab");
    add_row(0, 64'd42,                  1, 5,  0, 0,  0, 1, ROW_TEXT, "   42");
    add_row(1, 64'hff,                  0, 0,  0, 0,  0, 1, ROW_TEXT, "ff");
    add_row(1, 64'd0,                   1, 4,  0, 0,  0, 1, ROW_TEXT, "   0x0");
    add_row(0, 64'd42,                  0, 0,  1, 5,  0, 0, ROW_TEXT, "00042");
    add_row(0, 64'd12345,               0, 0,  1, 3,  0, 0, ROW_TEXT, "123");
    add_row(0, -64'd7,                  1, 6,  1, 3,  0, 0, ROW_TEXT, "-   007");
    add_row(0, 64'd3,                   1, 2,  1, 5,  0, 0, ROW_TEXT, "00003");
    add_row(0, 64'd5,                   1, 0,  0, 0,  0, 0, ROW_TEXT, "5");
    add_row(1, 64'd1,                   1, 31, 1, 31, 0, 1, ROW_PREDICT, "");
    add_row(0, 64'h8000_0000_0000_0000, 1, 31, 0, 0,  0, 1, ROW_PREDICT, "");
    add_row(1, 64'hffff_ffff_ffff_ffff, 1, 31, 0, 0,  0, 1, ROW_PREDICT, "");
    add_row(0, -64'd123456,             1, 30, 1, 9,  1, 1, ROW_PREDICT, "");
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i])
      send_conversion(dir_rows[i].f, dir_rows[i].v, dir_rows[i].kind, dir_rows[i].txt);
    for (int n = 0; n < RandItems; n++) begin
      if (n % 20 == 0) send_calm = ($urandom_range(0, 2) == 0);
      if (n == RandItems / 2) begin
        // let the block drain completely before going on
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_chars.size() != 0) @(posedge clk);
      end
      f = pick_format();
      send_conversion(f, pick_value(), ROW_PREDICT, "");
    end
    s_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // character side, with one long hold-off to back the block up
  initial begin : char_sink
    int  gap;
    int  got;
    int  calm_left;
    m_tready = 1'b0;
    got = 0;
    calm_left = 0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (calm_left > 0) begin
        calm_left--;
        gap = 0;
      end else begin
        if ($urandom_range(0, 30) == 0) calm_left = $urandom_range(10, 40);
        gap = $urandom_range(0, 10);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got++;
      if (got == 150) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
    end
  end

  // output check and watchdog
  always @(posedge clk) begin
    text_beat_t b;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        if (pending_chars.size() == 0) begin
          $error("unexpected beat: out_char %h last %b empty_res %b",
                 m_tdata, m_tlast, m_tuser);
          mismatches++;
        end else begin
          b = pending_chars.pop_front();
          if (m_tdata !== b.ch) begin
            $error("out_char: expected %h, got %h", b.ch, m_tdata);
            mismatches++;
          end
          if (m_tlast !== b.last) begin
            $error("last: expected %b, got %b", b.last, m_tlast);
            mismatches++;
          end
          if (m_tuser !== b.empty) begin
            $error("empty_res: expected %b, got %b", b.empty, m_tuser);
            mismatches++;
          end
        end
      end
    end
  end

endmodule

[files.f]
rtl/itf_pkg.sv
rtl/itf_conv.sv
rtl/itf_emit.sv
rtl/integer_text_formatter_core.sv
dv/tb_top.sv
